FILE: hw/rtl/mtss_pkg.sv
// Shared types, constants and the quarter-wave sine table for the test-signal source.
package mtss_pkg;

    localparam int MAX_CHANNELS     = 64;
    localparam int RECORD_DEPTH     = 512;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam int REC_AW  = $clog2(RECORD_DEPTH);
    localparam int SINE_KW = $clog2(SINE_TABLE_DEPTH);
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
    localparam int QAW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
    localparam logic [31:0] ONE_RADIAN_PHASE = 32'd683565276;
    localparam logic [31:0] SQUARE_AMPL      = 32'd32767;
    localparam logic [20:0] US_PER_S_X2      = 21'd2000000;

    // register indexes
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_CHAN_COUNT  = 3'd1;
    localparam logic [2:0] REG_SINE_STEP   = 3'd2;
    localparam logic [2:0] REG_SQUARE_STEP = 3'd3;
    localparam logic [2:0] REG_VOLT_SCALE  = 3'd4;

    // mode codes
    localparam logic [1:0] MODE_SINE   = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;
    localparam logic [1:0] MODE_PLAY   = 2'd2;

    // input function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_HEADER = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_HEADER,
        CMD_SAMPLE
    } mtss_cmd_kind_t;

    typedef struct packed {
        mtss_cmd_kind_t     kind;
        logic [31:0]        tick;
        logic [31:0]        sine_phase;
        logic               square_msb;
        logic [63:0]        hdr_time;
        logic [31:0]        hdr_rate;
        logic [9:0]         hdr_length;
        logic [8:0]         slot;
        logic signed [15:0] sample;
    } mtss_cmd_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  chan_count;
        logic [31:0] volt_scale;
    } mtss_cfg_t;

    typedef logic [SINE_TABLE_DEPTH:0][15:0] sine_tab_t;

    // Q30 Taylor sine, truncating, eight terms
    function automatic logic [15:0] sine_entry(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        v;
        x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        s = $signed(x);
        t = ((x * x2) >> 30) / 6;    s = s - $signed(t);
        t = ((t * x2) >> 30) / 20;   s = s + $signed(t);
        t = ((t * x2) >> 30) / 42;   s = s - $signed(t);
        t = ((t * x2) >> 30) / 72;   s = s + $signed(t);
        t = ((t * x2) >> 30) / 110;  s = s - $signed(t);
        t = ((t * x2) >> 30) / 156;  s = s + $signed(t);
        t = ((t * x2) >> 30) / 210;  s = s - $signed(t);
        if (s < 0) s = 0;
        v = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) v = 64'd32767;
        return v[15:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_table();

endpackage

FILE: hw/rtl/mtss_fifo.sv
// Short command queue between the front end and the back end.
module mtss_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mtss_pkg::mtss_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output mtss_pkg::mtss_cmd_t head
);
    import mtss_pkg::*;

    mtss_cmd_t        mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCW'(push && !full) - QCW'(pop && !empty);
        end
    end

endmodule

FILE: hw/rtl/mtss_front.sv
// Front end: configuration registers, item intake, phase accumulators, command queuing.
module mtss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         func,
    input  logic [8:0]         slot,
    input  logic signed [15:0] raw_sample,
    input  logic [63:0]        record_time_us,
    input  logic [31:0]        record_rate_hz,
    input  logic [9:0]         record_length,
    input  logic               q_full,
    output logic               q_push,
    output mtss_pkg::mtss_cmd_t q_data,
    output mtss_pkg::mtss_cfg_t cfg
);
    import mtss_pkg::*;

    logic [1:0]  mode_reg;
    logic [6:0]  chan_count_reg;
    logic [31:0] sine_step_reg;
    logic [31:0] square_step_reg;
    logic [31:0] volt_scale_reg;
    logic [31:0] tick_reg;
    logic [31:0] sine_phase_reg;
    logic [31:0] square_phase_reg;
    logic        accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    assign cfg.mode       = mode_reg;
    assign cfg.chan_count = chan_count_reg;
    assign cfg.volt_scale = volt_scale_reg;

    // func three is dropped here
    assign q_push = accept && (func != 2'd3);

    always_comb begin
        q_data            = '0;
        q_data.tick       = tick_reg;
        q_data.sine_phase = sine_phase_reg;
        q_data.square_msb = square_phase_reg[31];
        q_data.hdr_time   = record_time_us;
        q_data.hdr_rate   = record_rate_hz;
        q_data.hdr_length = record_length;
        q_data.slot       = slot;
        q_data.sample     = raw_sample;
        unique case (func)
            FUNC_TICK:   q_data.kind = CMD_TICK;
            FUNC_HEADER: q_data.kind = CMD_HEADER;
            FUNC_SAMPLE: q_data.kind = CMD_SAMPLE;
            default:     q_data.kind = CMD_TICK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg         <= MODE_SQUARE;
            chan_count_reg   <= 7'd32;
            sine_step_reg    <= 32'd42949673;
            square_step_reg  <= 32'd21474836;
            volt_scale_reg   <= '0;
            tick_reg         <= '0;
            sine_phase_reg   <= '0;
            square_phase_reg <= '0;
        end
        else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg        <= cfg_data[1:0];
                    REG_CHAN_COUNT:  chan_count_reg  <= cfg_data[6:0];
                    REG_SINE_STEP:   sine_step_reg   <= cfg_data;
                    REG_SQUARE_STEP: square_step_reg <= cfg_data;
                    REG_VOLT_SCALE:  volt_scale_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && func == FUNC_TICK) begin
                tick_reg         <= tick_reg + 32'd1;
                sine_phase_reg   <= sine_phase_reg + sine_step_reg;
                square_phase_reg <= square_phase_reg + square_step_reg;
            end
        end
    end

endmodule

FILE: hw/rtl/mtss_back.sv
// Back end: record store, channel sweep, playback interpolation and output register.
module mtss_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mtss_pkg::mtss_cfg_t cfg,
    input  logic                q_empty,
    input  mtss_pkg::mtss_cmd_t q_head,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [31:0]         timestamp,
    output logic [5:0]          channel,
    output logic signed [31:0]  value,
    output logic                last,
    output logic                record_done
);
    import mtss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYNTH,
        ST_PL_READ,
        ST_PL_DIV,
        ST_PL_OUT
    } state_t;

    state_t              state_reg;
    logic [15:0]         store [RECORD_DEPTH];
    logic [15:0]         rd_data_reg;

    logic [31:0]         tick_reg;
    logic [31:0]         ch_phase_reg;
    logic                square_msb_reg;
    logic [CH_W-1:0]     chan_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                norec_reg;

    logic [63:0]         hdr_time_reg;
    logic [31:0]         hdr_rate_reg;
    logic [9:0]          hdr_length_reg;
    logic                loaded_reg;
    logic [9:0]          pos_reg;
    logic [9:0]          pos_use_reg;

    logic [33:0]         num_reg;
    logic [32:0]         den_reg;
    logic [32:0]         rem_reg;
    logic [33:0]         quo_reg;
    logic [5:0]          div_cnt_reg;
    logic [47:0]         mag_reg;
    logic                neg_reg;

    logic                result_valid_reg;
    logic [31:0]         timestamp_reg;
    logic [5:0]          channel_reg;
    logic signed [31:0]  value_reg;
    logic                last_reg;
    logic                record_done_reg;

    logic                out_load;
    logic                emit;
    logic [CNT_W-1:0]    cnt_clamped;
    logic [9:0]          len_use;
    logic [9:0]          pos_use;
    logic [9:0]          pos_inc;
    logic                chan_last;
    logic [SINE_KW-1:0]  sine_k;
    logic [SINE_KW:0]    sine_idx;
    logic [15:0]         sine_mag;
    logic signed [31:0]  synth_val;
    logic [33:0]         rem_shift;
    logic                rem_ge;
    logic [15:0]         smp_abs;
    logic [48:0]         mag_rnd;
    logic [32:0]         r_val;
    logic signed [31:0]  play_val;
    logic [31:0]         offset;
    logic                sample_wr;

    assign result_valid = result_valid_reg;
    assign timestamp    = timestamp_reg;
    assign channel      = channel_reg;
    assign value        = value_reg;
    assign last         = last_reg;
    assign record_done  = record_done_reg;

    assign out_load = !result_valid_reg || !result_stall;
    assign emit     = out_load && ((state_reg == ST_SYNTH) || (state_reg == ST_PL_OUT));
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign sample_wr = q_pop && (q_head.kind == CMD_SAMPLE);

    // channel count clamped to 1..MAX_CHANNELS
    always_comb begin
        if (cfg.chan_count == '0) begin
            cnt_clamped = CNT_W'(1);
        end
        else if ({1'b0, cfg.chan_count} > 8'(MAX_CHANNELS)) begin
            cnt_clamped = CNT_W'(MAX_CHANNELS);
        end
        else begin
            cnt_clamped = CNT_W'(cfg.chan_count);
        end
    end

    // record length clamped to 1..RECORD_DEPTH
    always_comb begin
        if (hdr_length_reg == '0) begin
            len_use = 10'd1;
        end
        else if ({1'b0, hdr_length_reg} > 11'(RECORD_DEPTH)) begin
            len_use = 10'(RECORD_DEPTH);
        end
        else begin
            len_use = hdr_length_reg;
        end
    end

    assign pos_use   = (pos_reg >= len_use) ? 10'd0 : pos_reg;
    assign pos_inc   = pos_use_reg + 10'd1;
    assign chan_last = ({1'b0, chan_reg} == cnt_reg - CNT_W'(1));

    // quarter-wave lookup: mirror in odd quadrants, negate in the lower half
    assign sine_k   = ch_phase_reg[29 -: SINE_KW];
    assign sine_idx = ch_phase_reg[30] ? ((SINE_KW + 1)'(SINE_TABLE_DEPTH) - {1'b0, sine_k})
                                       : {1'b0, sine_k};
    assign sine_mag = SINE_TAB[sine_idx];

    always_comb begin
        case (cfg.mode)
            MODE_SINE:   synth_val = ch_phase_reg[31] ? -$signed({16'd0, sine_mag})
                                                      : $signed({16'd0, sine_mag});
            MODE_SQUARE: synth_val = square_msb_reg ? -$signed(SQUARE_AMPL)
                                                    : $signed(SQUARE_AMPL);
            default:     synth_val = '0;
        endcase
    end

    // restoring divider step
    assign rem_shift = {rem_reg, num_reg[33]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    assign smp_abs = rd_data_reg[15] ? (16'd0 - rd_data_reg) : rd_data_reg;

    // round half away from zero, then saturate
    assign mag_rnd = {1'b0, mag_reg} + 49'd32768;
    assign r_val   = mag_rnd[48:16];
    always_comb begin
        if (neg_reg) begin
            play_val = (r_val >= 33'h080000000) ? 32'sh80000000 : -$signed(r_val[31:0]);
        end
        else begin
            play_val = (r_val > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_val[31:0]);
        end
    end
    assign offset = (hdr_rate_reg == '0) ? 32'd0 : quo_reg[31:0];

    always_ff @(posedge clk) begin
        if (sample_wr) begin
            store[q_head.slot[REC_AW-1:0]] <= q_head.sample;
        end
        if (state_reg == ST_PL_READ) begin
            rd_data_reg <= store[pos_use[REC_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            hdr_time_reg     <= '0;
            hdr_rate_reg     <= '0;
            hdr_length_reg   <= '0;
            loaded_reg       <= 1'b0;
            pos_reg          <= '0;
            tick_reg         <= '0;
            ch_phase_reg     <= '0;
            square_msb_reg   <= 1'b0;
            chan_reg         <= '0;
            cnt_reg          <= '0;
            norec_reg        <= 1'b0;
            pos_use_reg      <= '0;
            num_reg          <= '0;
            den_reg          <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            div_cnt_reg      <= '0;
            mag_reg          <= '0;
            neg_reg          <= 1'b0;
            timestamp_reg    <= '0;
            channel_reg      <= '0;
            value_reg        <= '0;
            last_reg         <= 1'b0;
            record_done_reg  <= 1'b0;
        end
        else begin
            if (emit) begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        case (q_head.kind)
                            CMD_HEADER: begin
                                hdr_time_reg   <= q_head.hdr_time;
                                hdr_rate_reg   <= q_head.hdr_rate;
                                hdr_length_reg <= q_head.hdr_length;
                                loaded_reg     <= 1'b1;
                                pos_reg        <= '0;
                            end
                            CMD_TICK: begin
                                tick_reg       <= q_head.tick;
                                ch_phase_reg   <= q_head.sine_phase;
                                square_msb_reg <= q_head.square_msb;
                                chan_reg       <= '0;
                                cnt_reg        <= cnt_clamped;
                                norec_reg      <= !loaded_reg;
                                if (cfg.mode != MODE_PLAY) begin
                                    state_reg <= ST_SYNTH;
                                end
                                else if (!loaded_reg) begin
                                    state_reg <= ST_PL_OUT;
                                end
                                else begin
                                    state_reg <= ST_PL_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SYNTH: begin
                    if (out_load) begin
                        timestamp_reg    <= tick_reg;
                        channel_reg      <= 6'(chan_reg);
                        value_reg        <= synth_val;
                        last_reg         <= chan_last;
                        record_done_reg  <= 1'b0;
                        chan_reg         <= chan_reg + 1'b1;
                        ch_phase_reg     <= ch_phase_reg + ONE_RADIAN_PHASE;
                        if (chan_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_PL_READ: begin
                    pos_use_reg <= pos_use;
                    num_reg     <= 34'(pos_use) * 34'(US_PER_S_X2) + 34'(hdr_rate_reg);
                    den_reg     <= {hdr_rate_reg, 1'b0};
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_PL_DIV;
                end
                ST_PL_DIV: begin
                    mag_reg <= 48'(smp_abs) * 48'(cfg.volt_scale);
                    neg_reg <= rd_data_reg[15];
                    rem_reg <= rem_ge ? 33'(rem_shift - {1'b0, den_reg}) : rem_shift[32:0];
                    quo_reg <= {quo_reg[32:0], rem_ge};
                    num_reg <= {num_reg[32:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd33) begin
                        state_reg <= ST_PL_OUT;
                    end
                end
                ST_PL_OUT: begin
                    if (out_load) begin
                        channel_reg      <= '0;
                        last_reg         <= 1'b1;
                        if (norec_reg) begin
                            timestamp_reg   <= tick_reg;
                            value_reg       <= '0;
                            record_done_reg <= 1'b0;
                        end
                        else begin
                            timestamp_reg   <= hdr_time_reg[31:0] + offset;
                            value_reg       <= play_val;
                            record_done_reg <= (pos_inc >= len_use);
                            pos_reg         <= (pos_inc >= len_use) ? 10'd0 : pos_inc;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/multichannel_test_signal_source.sv
// Top level of the multichannel test-signal source.
// Tick-driven test-signal source. Each tick transfer (func 0) yields, in sine, square or unused
// mode, one result per channel (channel_count, clamped to 1..64) carrying the tick count as
// timestamp; in playback mode it yields one result, a zero stamped with the tick count before
// any header, else from the loaded record with an interpolated microsecond timestamp and a
// nanovolt value, record_done marking the last sample before the record wraps. Header (func 1)
// and sample (func 2) transfers load the record and yield nothing. A front end takes items and
// keeps the phase accumulators, a two-entry queue decouples it from the back end, which owns
// the record store and output register. A synthetic tick gives one output transfer per cycle
// while result_stall is low; a playback tick is dominated by the 34-step bit-serial divider
// for the time interpolation.
// Record store entries read before being written return undefined values. Configuration
// must be written only while the block is idle; cfg_ready is always high.
module multichannel_test_signal_source (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         func,
    input  logic [8:0]         slot,
    input  logic signed [15:0] raw_sample,
    input  logic [63:0]        record_time_us,
    input  logic [31:0]        record_rate_hz,
    input  logic [9:0]         record_length,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [31:0]        timestamp,
    output logic [5:0]         channel,
    output logic signed [31:0] value,
    output logic               last,
    output logic               record_done
);
    import mtss_pkg::*;

    mtss_cfg_t cfg;
    mtss_cmd_t push_data;
    mtss_cmd_t head;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    mtss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .slot           (slot),
        .raw_sample     (raw_sample),
        .record_time_us (record_time_us),
        .record_rate_hz (record_rate_hz),
        .record_length  (record_length),
        .q_full         (full),
        .q_push         (push),
        .q_data         (push_data),
        .cfg            (cfg)
    );

    // command queue: one entry per accepted tick or load transfer
    mtss_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    mtss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (empty),
        .q_head       (head),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .timestamp    (timestamp),
        .channel      (channel),
        .value        (value),
        .last         (last),
        .record_done  (record_done)
    );

endmodule

FILE: tb/sv/multichannel_test_signal_source_test.sv
// Self-checking testbench for the multichannel test-signal source.
module multichannel_test_signal_source_test;
    import mtss_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 600;

    // one output transfer as seen on the result channel
    typedef struct packed {
        logic [31:0]        ts;
        logic [5:0]         ch;
        logic signed [31:0] val;
        logic               last;
        logic               done;
    } source_out_t;

    // directed stimulus row: either a register write or an input item
    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [31:0]  data;
        logic [1:0]   f;
        logic [8:0]   sl;
        logic [15:0]  raw;
        logic [63:0]  tm;
        logic [31:0]  rate;
        logic [9:0]   len;
        bit           typed;
        source_out_t  want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [1:0]         func = '0;
    logic [8:0]         slot = '0;
    logic signed [15:0] raw_sample = '0;
    logic [63:0]        record_time_us = '0;
    logic [31:0]        record_rate_hz = '0;
    logic [9:0]         record_length = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [31:0]        timestamp;
    logic [5:0]         channel;
    logic signed [31:0] value;
    logic               last;
    logic               record_done;

    multichannel_test_signal_source dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .slot           (slot),
        .raw_sample     (raw_sample),
        .record_time_us (record_time_us),
        .record_rate_hz (record_rate_hz),
        .record_length  (record_length),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .timestamp      (timestamp),
        .channel        (channel),
        .value          (value),
        .last           (last),
        .record_done    (record_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: shadow registers and the block's internal state
    // ------------------------------------------------------------------
    logic [1:0]   sh_mode;
    logic [6:0]   sh_chan_count;
    logic [31:0]  sh_sine_step;
    logic [31:0]  sh_square_step;
    logic [31:0]  sh_volt_scale;

    logic [31:0]        tick_cnt;
    logic [9:0]         play_pos;
    logic signed [15:0] rec_mem [RECORD_DEPTH];
    bit                 rec_written [RECORD_DEPTH];
    logic [63:0]        hdr_time;
    logic [31:0]        hdr_rate;
    logic [9:0]         hdr_len;
    bit                 rec_loaded;
    logic [31:0]        sine_acc;
    logic [31:0]        square_acc;
    logic [15:0]        quarter_wave [SINE_TABLE_DEPTH + 1];

    source_out_t pending_results [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;     // no idling on either side
    int          hold_req = 0;     // bumped to ask for a long receiver hold-off

    // quarter-wave table: truncating Q30 Taylor series, eight terms
    task automatic build_quarter_wave();
        longint unsigned x, x2, term, v;
        longint          s;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            if (s < 0)
                s = 0;
            v = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
                v = 64'd32767;
            quarter_wave[i] = v[15:0];
        end
    endtask

    function automatic logic signed [31:0] sine_of(input logic [31:0] p);
        int          k;
        logic [15:0] mag;
        k = int'(p[29:22]);
        if (p[30])
            k = SINE_TABLE_DEPTH - k;
        mag = quarter_wave[k];
        return p[31] ? -$signed({16'd0, mag}) : $signed({16'd0, mag});
    endfunction

    function automatic int clamped_len();
        int n;
        n = int'(hdr_len);
        if (n < 1)
            n = 1;
        if (n > RECORD_DEPTH)
            n = RECORD_DEPTH;
        return n;
    endfunction

    // record position the next playback tick reads
    function automatic int next_play_pos();
        return (int'(play_pos) >= clamped_len()) ? 0 : int'(play_pos);
    endfunction

    // Works out what one accepted item does and queues the resulting transfers.
    task automatic predict_source(input logic [1:0] f, input logic [8:0] sl,
                                  input logic [15:0] raw, input logic [63:0] tm,
                                  input logic [31:0] rate, input logic [9:0] len);
        source_out_t     o;
        int              cnt, pos, n;
        longint unsigned off, mag, r;
        logic signed [15:0] s;
        if (f == FUNC_HEADER)
        begin
            hdr_time   = tm;
            hdr_rate   = rate;
            hdr_len    = len;
            rec_loaded = 1'b1;
            play_pos   = '0;
            return;
        end
        if (f == FUNC_SAMPLE)
        begin
            rec_mem[sl]     = raw;
            rec_written[sl] = 1'b1;
            return;
        end
        if (f != FUNC_TICK)
            return;

        if (sh_mode == MODE_PLAY)
        begin
            if (!rec_loaded)
            begin
                o = '{ts: tick_cnt, ch: '0, val: '0, last: 1'b1, done: 1'b0};
            end
            else
            begin
                n   = clamped_len();
                pos = next_play_pos();
                off = 0;
                if (hdr_rate != 0)
                    off = (longint'(pos) * 64'd2000000 + hdr_rate) / (64'(hdr_rate) * 2);
                s   = rec_mem[pos];
                mag = longint'(s < 0 ? -int'(s) : int'(s)) * 64'(sh_volt_scale);
                r   = (mag + 64'd32768) >> 16;
                o.ts = 32'(hdr_time + off);
                o.ch = '0;
                if (s < 0)
                    o.val = (r >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(r[31:0]);
                else
                    o.val = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
                o.last = 1'b1;
                pos++;
                o.done = (pos >= n);
                play_pos = (pos >= n) ? '0 : 10'(pos);
            end
            pending_results.push_back(o);
        end
        else
        begin
            cnt = int'(sh_chan_count);
            if (cnt < 1)
                cnt = 1;
            if (cnt > MAX_CHANNELS)
                cnt = MAX_CHANNELS;
            for (int c = 0; c < cnt; c++)
            begin
                o.ts = tick_cnt;
                o.ch = 6'(c);
                if (sh_mode == MODE_SINE)
                    o.val = sine_of(sine_acc + 32'(c) * ONE_RADIAN_PHASE);
                else if (sh_mode == MODE_SQUARE)
                    o.val = square_acc[31] ? -32'sd32767 : 32'sd32767;
                else
                    o.val = '0;
                o.last = (c + 1 == cnt);
                o.done = 1'b0;
                pending_results.push_back(o);
            end
        end
        tick_cnt   += 1;
        sine_acc   += sh_sine_step;
        square_acc += sh_square_step;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one item, with an occasional random gap in front; valid stays high afterwards
    // so that a following call can go on without a bubble.
    task automatic send_item(input logic [1:0] f, input logic [8:0] sl,
                             input logic [15:0] raw, input logic [63:0] tm,
                             input logic [31:0] rate, input logic [9:0] len);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        func           <= f;
        slot           <= sl;
        raw_sample     <= raw;
        record_time_us <= tm;
        record_rate_hz <= rate;
        record_length  <= len;
        do
            @(posedge clk);
        while (item_stall);
        predict_source(f, sl, raw, tm, rate, len);
    endtask

    // Block is idle once every expected transfer is out; loads give no
    // result, so let the longest per-item latency pass as well.
    task automatic wait_idle();
        item_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:        sh_mode        = data[1:0];
            REG_CHAN_COUNT:  sh_chan_count  = data[6:0];
            REG_SINE_STEP:   sh_sine_step   = data;
            REG_SQUARE_STEP: sh_square_step = data;
            REG_VOLT_SCALE:  sh_volt_scale  = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------
    int burst_left = 0;
    int hold_left  = 0;
    int hold_seen  = 0;

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(0, 9);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Checker: each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        source_out_t got, want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{ts: timestamp, ch: channel, val: value, last: last, done: record_done};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ts=%h ch=%0d val=%h last=%b done=%b",
                             got.ts, got.ch, got.val, got.last, got.done);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ts=%h ch=%0d val=%h last=%b done=%b, got ts=%h ch=%0d val=%h last=%b done=%b",
                                 want.ts, want.ch, want.val, want.last, want.done,
                                 got.ts, got.ch, got.val, got.last, got.done);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    stim_row_t rows [$];

    task automatic add_cfg(input logic [2:0] idx, input logic [31:0] data);
        stim_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        rows.push_back(r);
    endtask

    task automatic add_item(input logic [1:0] f, input logic [8:0] sl, input logic [15:0] raw,
                            input logic [63:0] tm, input logic [31:0] rate,
                            input logic [9:0] len);
        stim_row_t r;
        r      = '{default: '0};
        r.f    = f;
        r.sl   = sl;
        r.raw  = raw;
        r.tm   = tm;
        r.rate = rate;
        r.len  = len;
        rows.push_back(r);
    endtask

    // typed expectation for a playback tick with a single transfer
    task automatic add_play_tick(input logic [31:0] ts, input logic [31:0] val,
                                 input logic done);
        stim_row_t r;
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        r       = rows.pop_back();
        r.typed = 1'b1;
        r.want  = '{ts: ts, ch: '0, val: val, last: 1'b1, done: done};
        rows.push_back(r);
    endtask

    task automatic build_directed();
        // square tick at reset settings: 32 transfers
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_cfg(REG_MODE, 32'(MODE_PLAY));
        add_cfg(REG_VOLT_SCALE, 32'hFFFF_FFFF);
        // playback before any header: one zero transfer stamped with the tick count
        add_play_tick(32'd1, 32'd0, 1'b0);
        add_item(FUNC_HEADER, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 10'd2);
        add_item(FUNC_SAMPLE, 9'd0, 16'h8000, '0, '0, '0);
        add_item(FUNC_SAMPLE, 9'd1, 16'h7FFF, '0, '0, '0);
        // most negative sample at full scale saturates
        add_play_tick(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        // zero rate and zero length (treated as one sample)
        add_item(FUNC_HEADER, '0, '0, 64'd5, 32'd0, 10'd0);
        add_play_tick(32'd5, 32'h8000_0000, 1'b1);
        add_item(FUNC_HEADER, '0, '0, '0, 32'hFFFF_FFFF, 10'd1023);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_item(FUNC_SAMPLE, 9'd511, 16'd1, '0, '0, '0);
        add_item(2'd3, 9'h1FF, 16'hFFFF, '1, '1, '1);   // unused code, no result
        add_cfg(REG_MODE, 32'(MODE_SINE));
        add_cfg(REG_CHAN_COUNT, 32'd64);
        add_cfg(REG_SINE_STEP, 32'd0);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_cfg(REG_SINE_STEP, 32'hFFFF_FFFF);
        add_cfg(REG_CHAN_COUNT, 32'd0);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_cfg(REG_MODE, 32'd3);                      // unused mode emits zeros
        add_cfg(REG_CHAN_COUNT, 32'd127);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_cfg(REG_MODE, 32'(MODE_SQUARE));
        add_cfg(REG_CHAN_COUNT, 32'd3);
        add_cfg(REG_SQUARE_STEP, 32'h8000_0000);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_item(FUNC_TICK, '0, '0, '0, '0, '0);
        add_cfg(REG_VOLT_SCALE, 32'd0);
    endtask

    // ------------------------------------------------------------------
    // Random part helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config();
        int          m;
        logic [31:0] cc;
        m = $urandom_range(0, 9);
        write_reg(REG_MODE, (m < 4) ? 32'(MODE_PLAY) : (m < 6) ? 32'(MODE_SINE) :
                            (m < 8) ? 32'(MODE_SQUARE) : 32'd3);
        case ($urandom_range(0, 9))
            0:       cc = 32'd64;
            1:       cc = 32'd0;
            2:       cc = $urandom_range(65, 127);
            default: cc = $urandom_range(1, 8);
        endcase
        write_reg(REG_CHAN_COUNT, cc);
        write_reg(REG_SINE_STEP, pick_word());
        write_reg(REG_SQUARE_STEP, pick_word());
        write_reg(REG_VOLT_SCALE, ($urandom_range(0, 2) == 0) ? pick_word()
                                                               : $urandom_range(0, 32'h0100_0000));
    endtask

    task automatic random_item();
        int          w, p;
        logic [9:0]  len;
        logic [31:0] rate;
        w = $urandom_range(0, 99);
        if (w < 65)
        begin
            // never read a store entry that was never written
            if (sh_mode == MODE_PLAY && rec_loaded)
            begin
                p = next_play_pos();
                if (!rec_written[p])
                    send_item(FUNC_SAMPLE, 9'(p), 16'($urandom), '0, '0, '0);
            end
            send_item(FUNC_TICK, 9'($urandom), 16'($urandom), {$urandom, $urandom},
                      $urandom, 10'($urandom));
        end
        else if (w < 85)
        begin
            send_item(FUNC_SAMPLE, ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                               : 9'($urandom_range(0, 15)),
                      16'($urandom), {$urandom, $urandom}, $urandom, 10'($urandom));
        end
        else if (w < 97)
        begin
            case ($urandom_range(0, 9))
                0:       len = 10'd0;
                1:       len = 10'd512;
                2:       len = 10'($urandom_range(513, 1023));
                default: len = 10'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 7))
                0:       rate = 32'd0;
                1:       rate = 32'd1;
                2:       rate = 32'hFFFF_FFFF;
                default: rate = $urandom_range(1, 100000);
            endcase
            send_item(FUNC_HEADER, 9'($urandom), 16'($urandom), {$urandom, $urandom},
                      rate, len);
        end
        else
        begin
            send_item(2'd3, 9'($urandom), 16'($urandom), {$urandom, $urandom},
                      $urandom, 10'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t r;
        build_quarter_wave();
        sh_mode        = MODE_SQUARE;
        sh_chan_count  = 7'd32;
        sh_sine_step   = 32'd42949673;
        sh_square_step = 32'd21474836;
        sh_volt_scale  = '0;
        tick_cnt   = '0;
        play_pos   = '0;
        hdr_time   = '0;
        hdr_rate   = '0;
        hdr_len    = '0;
        rec_loaded = 1'b0;
        sine_acc   = '0;
        square_acc = '0;
        foreach (rec_written[i])
            rec_written[i] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        build_directed();
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.is_cfg)
            begin
                wait_idle();
                write_reg(r.idx, r.data);
            end
            else
            begin
                send_item(r.f, r.sl, r.raw, r.tm, r.rate, r.len);
                if (r.typed)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(r.want);
                end
            end
        end

        // random phases; the second one holds the receiver off for a long
        // stretch while items keep coming, the last one has no idling
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            quiet = (ph == 7) || ($urandom_range(0, 3) == 0);
            random_config();
            if (ph == 1)
            begin
                write_reg(REG_MODE, 32'(MODE_SQUARE));
                hold_req++;
            end
            for (int n = 0; n < 55; n++)
                random_item();
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
